[hw/rtl/text_console_writer_defines.svh]
// Assertion macros shared by the checker.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TCW_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TCW_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tcw_pkg.sv]
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;
    localparam int CELL_W      = 16;   // {char, attr}

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MARGIN = 2'd2;

    localparam logic [3:0] FORE_RESET = 4'd7;

    typedef enum logic [1:0] {
        REQ_PRINT  = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_SCROLL = 2'd2,
        REQ_READ   = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } req_item_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
    } rsp_item_t;

    // Range kinds of the datapath sweep engine.
    typedef enum logic [2:0] {
        SW_ZERO,     // whole screen to zero (reset pass)
        SW_CLEAR,    // whole screen to space/attr
        SW_TAIL,     // cursor column to row end, space/attr
        SW_COPY,     // move rows up by one
        SW_BOTTOM,   // bottom row to zero
        SW_HEAD      // row start to margin, space/attr
    } sweep_kind_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_NEWLINE,
        CUR_ADVANCE,
        CUR_HOME,
        CUR_SCROLL
    } cur_op_t;

    typedef struct packed {
        logic        load_in;
        logic        sweep_start;
        sweep_kind_t kind;
        logic        put_char;
        cur_op_t     cur_op;
        logic        load_result;
    } dp_cmd_t;

    typedef struct packed {
        req_type_t req;
        logic      newline;
        logic      col_full;
        logic      bottom;
        logic      busy;
    } dp_stat_t;

endpackage

[hw/rtl/text_console_writer.sv]
// One request in flight at a time: the next one is taken the cycle after
// the response loads. The single write port of the screen RAM takes one
// cell per cycle. Reset: cursor to 0,0, colors to 7/0, margin 0, then a
// clearing pass zeroes the screen while req_stall stays high.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port (no read-back)
    input  logic                           cfg_wr_en,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  logic                           req_valid,
    output logic                           req_stall,
    input  tcw_pkg::req_item_t             req_item,
    // response channel
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output tcw_pkg::rsp_item_t             rsp_item
);

    // The controller sequences each request as a series of datapath
    // operations: a sweep over a cell range (fill, row copy, zero), a
    // single character write, and a cursor update. The datapath owns the
    // screen RAM, the cursor, the config registers and the response
    // register.
    tcw_pkg::dp_cmd_t  cmd;
    tcw_pkg::dp_stat_t stat;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // The response register decouples the two sides: a new request can
    // be taken while the previous response still waits for its transfer.
    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_item  (req_item),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_item  (rsp_item)
    );

endmodule

[hw/rtl/tcw_ram.sv]
module tcw_ram #(
    parameter int WIDTH = tcw_pkg::CELL_W,
    parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

[hw/rtl/tcw_ctrl.sv]
module tcw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output tcw_pkg::dp_cmd_t  cmd,
    input  tcw_pkg::dp_stat_t stat
);

    typedef enum logic [3:0] {
        S_INIT,
        S_INIT_W,
        S_IDLE,
        S_DECODE,
        S_TAIL_W,
        S_COPY_W,
        S_BOT_W,
        S_HEAD_S,
        S_HEAD_W,
        S_PUT,
        S_CLR_W,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd            = '0;
        cmd.kind       = tcw_pkg::SW_ZERO;
        cmd.cur_op     = tcw_pkg::CUR_HOLD;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                cmd.sweep_start = 1'b1;
                cmd.kind        = tcw_pkg::SW_ZERO;
                state_next      = S_INIT_W;
            end
            S_INIT_W:
            begin
                if (!stat.busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.req)
                    tcw_pkg::REQ_PRINT:
                    begin
                        if (stat.newline || stat.col_full)
                        begin
                            cmd.sweep_start = 1'b1;
                            cmd.kind        = tcw_pkg::SW_TAIL;
                            state_next      = S_TAIL_W;
                        end
                        else
                        begin
                            state_next = S_PUT;
                        end
                    end
                    tcw_pkg::REQ_CLEAR:
                    begin
                        cmd.sweep_start = 1'b1;
                        cmd.kind        = tcw_pkg::SW_CLEAR;
                        state_next      = S_CLR_W;
                    end
                    tcw_pkg::REQ_SCROLL:
                    begin
                        cmd.sweep_start = 1'b1;
                        cmd.kind        = tcw_pkg::SW_COPY;
                        state_next      = S_COPY_W;
                    end
                    tcw_pkg::REQ_READ:
                    begin
                        // read issued this cycle, data valid next
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_TAIL_W:
            begin
                if (!stat.busy)
                begin
                    if (stat.bottom)
                    begin
                        cmd.sweep_start = 1'b1;
                        cmd.kind        = tcw_pkg::SW_COPY;
                        state_next      = S_COPY_W;
                    end
                    else
                    begin
                        cmd.cur_op = tcw_pkg::CUR_NEWLINE;
                        state_next = S_HEAD_S;
                    end
                end
            end
            S_COPY_W:
            begin
                if (!stat.busy)
                begin
                    cmd.sweep_start = 1'b1;
                    cmd.kind        = tcw_pkg::SW_BOTTOM;
                    state_next      = S_BOT_W;
                end
            end
            S_BOT_W:
            begin
                if (!stat.busy)
                begin
                    if (stat.req == tcw_pkg::REQ_SCROLL)
                    begin
                        cmd.cur_op = tcw_pkg::CUR_SCROLL;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.cur_op = tcw_pkg::CUR_NEWLINE;
                        state_next = S_HEAD_S;
                    end
                end
            end
            S_HEAD_S:
            begin
                cmd.sweep_start = 1'b1;
                cmd.kind        = tcw_pkg::SW_HEAD;
                state_next      = S_HEAD_W;
            end
            S_HEAD_W:
            begin
                if (!stat.busy)
                begin
                    state_next = stat.newline ? S_FINISH : S_PUT;
                end
            end
            S_PUT:
            begin
                cmd.put_char = 1'b1;
                cmd.cur_op   = tcw_pkg::CUR_ADVANCE;
                state_next   = S_FINISH;
            end
            S_CLR_W:
            begin
                if (!stat.busy)
                begin
                    cmd.cur_op = tcw_pkg::CUR_HOME;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.load_result = 1'b1;
                    rsp_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

[hw/rtl/tcw_dp.sv]
module tcw_dp #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  tcw_pkg::req_item_t               req_item,
    input  tcw_pkg::dp_cmd_t                 cmd,
    output tcw_pkg::dp_stat_t                stat,
    output tcw_pkg::rsp_item_t               rsp_item
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = $clog2(CELLS + 1);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int RW    = $clog2(ROWS);

    logic [3:0]              fore_reg, back_reg;
    logic [6:0]              margin_reg;
    tcw_pkg::req_type_t      req_reg;
    logic [7:0]              char_reg;
    logic [10:0]             idx_reg;
    logic [CW-1:0]           col_reg;
    logic [RW-1:0]           row_reg;
    logic [PW-1:0]           ptr_reg, hi_reg;
    tcw_pkg::sweep_kind_t    kind_reg;
    logic                    pend_reg;
    logic [AW-1:0]           pend_addr_reg;
    tcw_pkg::rsp_item_t      rsp_reg;

    logic [7:0]              attr;
    logic [CW-1:0]           eff_margin;
    logic [PW-1:0]           base;
    logic                    active, copy_active, read_hit;
    logic [PW-1:0]           lo_start, hi_start;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic [tcw_pkg::CELL_W-1:0] wr_data, rd_data;

    assign attr = {back_reg, fore_reg};

    always_comb
    begin
        if (32'(margin_reg) >= COLUMNS)
        begin
            eff_margin = CW'(COLUMNS - 1);
        end
        else
        begin
            eff_margin = CW'(margin_reg);
        end
    end

    assign base        = PW'(32'(row_reg) * COLUMNS);
    assign active      = (ptr_reg != hi_reg);
    assign copy_active = active && (kind_reg == tcw_pkg::SW_COPY);
    assign read_hit    = (req_reg == tcw_pkg::REQ_READ) && (32'(idx_reg) < CELLS);

    always_comb
    begin
        unique case (cmd.kind)
            tcw_pkg::SW_ZERO, tcw_pkg::SW_CLEAR:
            begin
                lo_start = '0;
                hi_start = PW'(CELLS);
            end
            tcw_pkg::SW_TAIL:
            begin
                lo_start = base + PW'(col_reg);
                hi_start = base + PW'(COLUMNS);
            end
            tcw_pkg::SW_COPY:
            begin
                lo_start = '0;
                hi_start = PW'(CELLS - COLUMNS);
            end
            tcw_pkg::SW_BOTTOM:
            begin
                lo_start = PW'(CELLS - COLUMNS);
                hi_start = PW'(CELLS);
            end
            tcw_pkg::SW_HEAD:
            begin
                lo_start = base;
                hi_start = base + PW'(eff_margin);
            end
            default:
            begin
                lo_start = '0;
                hi_start = '0;
            end
        endcase
    end

    // copy reads one row ahead; the write lands via pend_reg
    assign rd_addr = copy_active ? AW'(ptr_reg + PW'(COLUMNS)) : AW'(idx_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = AW'(ptr_reg);
        wr_data = '0;
        priority if (cmd.put_char)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(base + PW'(col_reg));
            wr_data = {char_reg, attr};
        end
        else if (pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = rd_data;
        end
        else if (active && (kind_reg != tcw_pkg::SW_COPY))
        begin
            wr_en = 1'b1;
            if (kind_reg == tcw_pkg::SW_ZERO || kind_reg == tcw_pkg::SW_BOTTOM)
            begin
                wr_data = '0;
            end
            else
            begin
                wr_data = {tcw_pkg::SPACE_CODE, attr};
            end
        end
    end

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_reg   <= tcw_pkg::FORE_RESET;
            back_reg   <= '0;
            margin_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            ptr_reg    <= '0;
            hi_reg     <= '0;
            kind_reg   <= tcw_pkg::SW_ZERO;
            pend_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == tcw_pkg::CFG_FORE_COLOR)
                begin
                    fore_reg <= cfg_data[3:0];
                end
                else if (cfg_index == tcw_pkg::CFG_BACK_COLOR)
                begin
                    back_reg <= cfg_data[3:0];
                end
                else if (cfg_index == tcw_pkg::CFG_LEFT_MARGIN)
                begin
                    margin_reg <= cfg_data;
                end
            end

            if (cmd.sweep_start)
            begin
                ptr_reg  <= lo_start;
                hi_reg   <= hi_start;
                kind_reg <= cmd.kind;
                pend_reg <= 1'b0;
            end
            else
            begin
                if (active)
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
                pend_reg <= copy_active;
            end

            unique case (cmd.cur_op)
                tcw_pkg::CUR_HOLD:
                begin
                end
                tcw_pkg::CUR_NEWLINE:
                begin
                    if (32'(row_reg) + 1 >= ROWS)
                    begin
                        row_reg <= RW'(ROWS - 1);
                    end
                    else
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                    col_reg <= eff_margin;
                end
                tcw_pkg::CUR_ADVANCE:
                begin
                    col_reg <= col_reg + 1'b1;
                end
                tcw_pkg::CUR_HOME:
                begin
                    row_reg <= '0;
                    col_reg <= eff_margin;
                end
                tcw_pkg::CUR_SCROLL:
                begin
                    if (row_reg != '0)
                    begin
                        row_reg <= row_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= AW'(ptr_reg);
        if (cmd.load_in)
        begin
            req_reg  <= req_item.req_type;
            char_reg <= req_item.char_code;
            idx_reg  <= req_item.cell_index;
        end
        if (cmd.load_result)
        begin
            rsp_reg.cell_char  <= read_hit ? rd_data[15:8] : 8'd0;
            rsp_reg.cell_attr  <= read_hit ? rd_data[7:0]  : 8'd0;
            rsp_reg.cursor_col <= 7'(col_reg);
            rsp_reg.cursor_row <= 5'(row_reg);
        end
    end

    assign stat.req      = req_reg;
    assign stat.newline  = (char_reg == tcw_pkg::NEWLINE_CODE);
    assign stat.col_full = (32'(col_reg) >= COLUMNS);
    assign stat.bottom   = (32'(row_reg) + 1 >= ROWS);
    assign stat.busy     = active || pend_reg;

    assign rsp_item = rsp_reg;

endmodule

[hw/rtl/tcw_checker.sv]
`include "text_console_writer_defines.svh"

module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_stall,
    input logic                           rsp_valid,
    input logic                           rsp_stall,
    input tcw_pkg::rsp_item_t             rsp_item
);

    `TCW_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item), "response changed while stalled")
    `TCW_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && !req_stall, req_stall, "request accepted on consecutive cycles")
    `TCW_ASSERT_IMPL(a_row_range, clk, rst_n, rsp_valid, 32'(rsp_item.cursor_row) < ROWS, "cursor row out of range")
    `TCW_ASSERT_IMPL(a_col_range, clk, rst_n, rsp_valid, 32'(rsp_item.cursor_col) <= COLUMNS, "cursor column out of range")

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (.*);
